/* rtl/core/okl_pkg.sv */
package okl_pkg;

  localparam int OKL_CAPACITY = 16;
  localparam int OKL_KEY_BITS = 32;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_DUMP      = 2'd3
  } okl_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_DUMP      = 3'd5
  } okl_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SCAN,
    S_SHIFT,
    S_DUMP
  } okl_state_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_CUR,
    RD_NEXT,
    RD_NEXT2
  } okl_rd_sel_e;

  typedef struct packed {
    logic        accept;
    logic        wr_front;
    logic        wr_back;
    logic        s_clear;
    logic        s_adv;
    logic        shift;
    logic        occ_dec;
    logic        set_status;
    okl_status_e status;
    logic        res_load;
    logic        res_dump;
    okl_rd_sel_e rd_sel;
  } okl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic s_last;
    logic out_free;
  } okl_sts_t;

endpackage

/* rtl/core/okl_if.sv */
interface okl_in_if
  import okl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

interface okl_out_if
  import okl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_out;
  logic [POS_W-1:0]    position;
  logic                last;

  modport source (output valid, output status, output key_out, output position,
                  output last, input ready);
  modport sink (input valid, input status, input key_out, input position,
                input last, output ready);
endinterface

/* rtl/core/okl_ram.sv */
module okl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/okl_ctrl.sv */
module okl_ctrl
  import okl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] opcode_i,
  output logic            in_ready_o,
  input  okl_sts_t        sts_i,
  output okl_cmd_t        cmd_o
);

  okl_state_e state_q, state_d;
  okl_op_e    op;

  assign op = okl_op_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_REMOVE: state_d = sts_i.empty ? S_RESP : S_SCAN;
            OP_DUMP:   state_d = sts_i.empty ? S_RESP : S_DUMP;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          state_d = sts_i.s_last ? S_RESP : S_SHIFT;
        end else if (sts_i.s_last) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (sts_i.s_last) begin
          state_d = S_RESP;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free && sts_i.s_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ST_INSERTED;
    cmd_o.rd_sel = RD_HEAD;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
              cmd_o.set_status = 1'b1;
              if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.status   = ST_INSERTED;
                cmd_o.wr_front = (op == OP_INS_FRONT);
                cmd_o.wr_back  = (op == OP_INS_BACK);
              end
            end
            default: begin
              if (sts_i.empty) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_EMPTY;
              end else begin
                cmd_o.s_clear = 1'b1;
              end
            end
          endcase
        end
      end
      S_RESP: begin
        cmd_o.res_load = sts_i.out_free;
      end
      S_SCAN: begin
        cmd_o.rd_sel = RD_NEXT;
        if (sts_i.match) begin
          cmd_o.occ_dec = 1'b1;
          if (sts_i.s_last) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_REMOVED;
          end
        end else if (sts_i.s_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_FOUND;
        end else begin
          cmd_o.s_adv = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_sel = RD_NEXT2;
        cmd_o.shift  = 1'b1;
        if (sts_i.s_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_REMOVED;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_dump = 1'b1;
          cmd_o.s_adv    = 1'b1;
          cmd_o.rd_sel   = RD_NEXT;
        end else begin
          cmd_o.rd_sel = RD_CUR;
        end
      end
      default: begin
        cmd_o.rd_sel = RD_HEAD;
      end
    endcase
  end

endmodule

/* rtl/core/okl_dp.sv */
module okl_dp
  import okl_pkg::*;
#(
  parameter int CAPACITY = OKL_CAPACITY,
  parameter int KEY_BITS = OKL_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_W-1:0]    key_i,
  input  okl_cmd_t            cmd_i,
  output okl_sts_t            sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [KEY_W-1:0]    key_out_o,
  output logic [POS_W-1:0]    position_o,
  output logic                last_o
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = IW + 2;

  logic [IW-1:0]  head_q, head_d;
  logic [CW-1:0]  occ_q, occ_d;
  logic [IW-1:0]  s_q, s_d;
  logic [KW-1:0]  key_q;
  okl_status_e    status_q;
  logic           out_valid_q, out_valid_d;

  logic [STATUS_W-1:0] res_status_q;
  logic [KEY_W-1:0]    res_key_q;
  logic [POS_W-1:0]    res_pos_q;
  logic                res_last_q;

  logic           we;
  logic [IW-1:0]  waddr, raddr;
  logic [KW-1:0]  wdata, rdata;
  logic [IW-1:0]  head_dec;
  logic [31:0]    pos_full;
  logic           s_last;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [OW-1:0] off);
    logic [OW-1:0] sum;
    sum = OW'(head) + off;
    if (sum >= OW'(CAPACITY)) begin
      sum = sum - OW'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign head_dec = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
  assign s_last   = (CW'(s_q) == occ_q - CW'(1));
  assign pos_full = 32'(s_q) + 32'd1;

  always_comb begin
    we    = 1'b0;
    waddr = head_dec;
    wdata = key_i[KW-1:0];
    if (cmd_i.wr_front) begin
      we = 1'b1;
    end else if (cmd_i.wr_back) begin
      we    = 1'b1;
      waddr = phys(head_q, OW'(occ_q));
    end else if (cmd_i.shift) begin
      we    = 1'b1;
      waddr = phys(head_q, OW'(s_q));
      wdata = rdata;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_CUR:   raddr = phys(head_q, OW'(s_q));
      RD_NEXT:  raddr = phys(head_q, OW'(s_q) + OW'(1));
      RD_NEXT2: raddr = phys(head_q, OW'(s_q) + OW'(2));
      default:  raddr = head_q;
    endcase
  end

  okl_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    head_d      = head_q;
    occ_d       = occ_q;
    s_d         = s_q;
    out_valid_d = out_valid_q;
    if (cmd_i.wr_front) begin
      head_d = head_dec;
    end
    if (cmd_i.wr_front || cmd_i.wr_back) begin
      occ_d = occ_q + CW'(1);
    end else if (cmd_i.occ_dec) begin
      occ_d = occ_q - CW'(1);
    end
    if (cmd_i.s_clear) begin
      s_d = '0;
    end else if (cmd_i.s_adv || cmd_i.shift) begin
      s_d = s_q + IW'(1);
    end
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    if (cmd_i.accept) begin
      key_q <= key_i[KW-1:0];
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.res_load) begin
      if (cmd_i.res_dump) begin
        res_status_q <= ST_DUMP;
        res_key_q    <= KEY_W'(rdata);
        res_pos_q    <= pos_full[POS_W-1:0];
        res_last_q   <= s_last;
      end else begin
        res_status_q <= status_q;
        res_key_q    <= (status_q == ST_REMOVED) ? KEY_W'(key_q) : '0;
        res_pos_q    <= '0;
        res_last_q   <= 1'b1;
      end
    end
  end

  assign sts_o.full     = (occ_q == CW'(CAPACITY));
  assign sts_o.empty    = (occ_q == '0);
  assign sts_o.match    = (rdata == key_q);
  assign sts_o.s_last   = s_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = res_status_q;
  assign key_out_o   = res_key_q;
  assign position_o  = res_pos_q;
  assign last_o      = res_last_q;

endmodule

/* rtl/core/ordered_key_list.sv */
// Ordered key list, up to CAPACITY keys kept in a ring buffer RAM.
// in_i carries opcode and key: insert at front, insert at back, remove the
// first entry equal to key, or dump all entries in order.
// out_o carries status, key_out, position and last; last marks the final
// result of an item. An item is accepted while the controller is idle.
// Steps from acceptance to the result in the output register:
//   insert, full, empty:       the status is answered directly
//   remove:                    a scan from the head up to the match, then
//                              a shift of every entry behind the removed
//                              one to close the gap (not found: a full scan)
//   dump:                      one entry per cycle while out_o is ready
// The single RAM port pair (one write, one registered read) sets this
// pace: search and gap closing walk the list one entry a cycle.
// The output register lets the next item be accepted while a result waits.
// When out_o stalls, a dump holds its place and resumes when drained.
// Reset empties the list and drops any pending result; the RAM needs no
// clearing pass.
module ordered_key_list
  import okl_pkg::*;
#(
  parameter int CAPACITY = OKL_CAPACITY,
  parameter int KEY_BITS = OKL_KEY_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  okl_in_if.sink           in_i,
  okl_out_if.source        out_o
);

  okl_cmd_t cmd;
  okl_sts_t sts;

  okl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  okl_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (in_i.key),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (out_o.status),
    .key_out_o   (out_o.key_out),
    .position_o  (out_o.position),
    .last_o      (out_o.last)
  );

endmodule

/* verif/ordered_key_list_tb.sv */
`timescale 1ns / 1ps

module ordered_key_list_tb;
  import okl_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_ITEMS = 435;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    okl_status_e        status;
    logic [KEY_W-1:0]   key_out;
    logic [POS_W-1:0]   position;
    logic               last;
  } list_result_t;

  class list_scoreboard;
    logic [KEY_W-1:0] cells[$];
    list_result_t     expected_results[$];
    int               errors;
    int               items_seen;
    int               results_checked;
    int               full_hits;
    int               removals;
    int               dump_entries;

    function new();
      errors = 0;
      items_seen = 0;
      results_checked = 0;
      full_hits = 0;
      removals = 0;
      dump_entries = 0;
    endfunction

    function void expect_result(okl_status_e st, logic [KEY_W-1:0] k,
                                logic [POS_W-1:0] pos, logic lst);
      list_result_t r;
      r.status = st;
      r.key_out = k;
      r.position = pos;
      r.last = lst;
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_item(okl_op_e op, logic [KEY_W-1:0] k);
      int hit;
      items_seen++;
      case (op)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (cells.size() >= OKL_CAPACITY) begin
            full_hits++;
            expect_result(ST_FULL, '0, '0, 1'b1);
          end else begin
            if (op == OP_INS_FRONT) cells.push_front(k);
            else cells.push_back(k);
            expect_result(ST_INSERTED, '0, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (cells.size() == 0) begin
            expect_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            hit = -1;
            for (int i = 0; i < cells.size(); i++) begin
              if (hit < 0 && cells[i] == k) hit = i;
            end
            if (hit < 0) begin
              expect_result(ST_NOT_FOUND, '0, '0, 1'b1);
            end else begin
              cells.delete(hit);
              removals++;
              expect_result(ST_REMOVED, k, '0, 1'b1);
            end
          end
        end
        default: begin
          if (cells.size() == 0) begin
            expect_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < cells.size(); i++) begin
              dump_entries++;
              expect_result(ST_DUMP, cells[i], POS_W'(i + 1), i == cells.size() - 1);
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
                               logic [POS_W-1:0] pos, logic lst);
      list_result_t e;
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d key_out %0h position %0d last %0d",
               st, k, pos, lst);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (k !== e.key_out) begin
        $error("key_out: expected %0h, actual %0h", e.key_out, k);
        errors++;
      end
      if (pos !== e.position) begin
        $error("position: expected %0d, actual %0d", e.position, pos);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   cycles = 0;

  list_scoreboard sb;

  okl_in_if  in_if ();
  okl_out_if out_if ();

  ordered_key_list dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.status, out_if.key_out, out_if.position, out_if.last);
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_item(okl_op_e op, logic [KEY_W-1:0] k);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.key <= k;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(op, k);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_remove_key();
    if (sb.cells.size() > 0 && $urandom_range(0, 9) < 7) begin
      return sb.cells[$urandom_range(0, sb.cells.size() - 1)];
    end
    return pick_key();
  endfunction

  task automatic run_random(int n);
    int grow_pct;
    int rem_pct;
    int left;
    int roll;
    left = 0;
    grow_pct = 50;
    rem_pct = 40;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(20, 40);
        case ($urandom_range(0, 2))
          0: begin grow_pct = 75; rem_pct = 15; end
          1: begin grow_pct = 20; rem_pct = 70; end
          default: begin grow_pct = 45; rem_pct = 45; end
        endcase
      end
      left--;
      if (i == n - CALM_ITEMS) calm = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < grow_pct) begin
        send_item($urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT, pick_key());
      end else if (roll < grow_pct + rem_pct) begin
        send_item(OP_REMOVE, pick_remove_key());
      end else begin
        send_item(OP_DUMP, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_INS_FRONT;
    in_if.key <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_DUMP, $urandom);
    send_item(OP_REMOVE, 32'h0000_0007);
    send_item(OP_INS_BACK, '0);
    send_item(OP_INS_FRONT, '1);
    send_item(OP_INS_BACK, '1);
    send_item(OP_REMOVE, '1);
    send_item(OP_DUMP, '0);
    send_item(OP_REMOVE, 32'h1234_5678);
    for (int i = 0; i < OKL_CAPACITY - 2; i++) begin
      send_item(i[0] ? OP_INS_BACK : OP_INS_FRONT, $urandom);
    end
    send_item(OP_INS_FRONT, 32'h8000_0001);
    send_item(OP_INS_BACK, 32'h7FFF_FFFE);
    send_item(OP_DUMP, '1);

    run_random(RANDOM_ITEMS);
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items, %0d results: %0d list-full inserts, %0d removals,",
             sb.items_seen, sb.results_checked, sb.full_hits, sb.removals);
    $display("%0d dumped entries, with random stalls on both channels.", sb.dump_entries);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
